// File: hw/rtl/vector3_normalize_top_assert.svh
// Assertion macros for the vector normalization top level
`ifndef VECTOR3_NORMALIZE_TOP_ASSERT_SVH
`define VECTOR3_NORMALIZE_TOP_ASSERT_SVH

`define V3N_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define V3N_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/v3n_pkg.sv
// Package: widths and pipeline depth of the vector normalizer
package v3n_pkg;
  localparam int unsigned CompW    = 32;
  localparam int unsigned FracW    = 30;
  localparam int unsigned MagW     = CompW;
  localparam int unsigned SqW      = 2 * MagW;
  localparam int unsigned RootW    = MagW + 1;
  localparam int unsigned SqrtSteps = SqW / 2;
  localparam int unsigned DivW     = MagW + FracW;
  localparam int unsigned QuoW     = FracW + 1;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned Depth    = 3 + SqrtSteps + DivSteps + 1;

  typedef struct packed {
    logic [MagW-1:0] mag;
    logic            neg;
  } comp_t;
endpackage

// File: hw/rtl/v3n_sqrt.sv
// Pipelined floor square root, one result bit per stage
module v3n_sqrt (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [v3n_pkg::SqW-1:0]        rad_i,
  output logic [v3n_pkg::RootW-1:0]      root_o
);
  localparam int unsigned N = v3n_pkg::SqrtSteps;
  localparam int unsigned W = v3n_pkg::SqW;
  localparam int unsigned RW = W / 2 + 2;

  logic [W-1:0]  rad_q  [N+1];
  logic [RW-1:0] rem_q  [N+1];
  logic [RW-1:0] root_q [N+1];

  always_comb begin
    rad_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rem_d, trial_d, root_d;
    logic [W-1:0]  rad_d;
    always_comb begin
      rem_d   = {rem_q[k][RW-3:0], rad_q[k][W-1 -: 2]};
      trial_d = {root_q[k][RW-3:0], 2'b01};
      rad_d   = {rad_q[k][W-3:0], 2'b00};
      root_d  = {root_q[k][RW-2:0], 1'b0};
      if (rem_d >= trial_d) begin
        rem_d  = rem_d - trial_d;
        root_d = {root_q[k][RW-2:0], 1'b1};
      end
    end
    logic [W-1:0]  rad_r;
    logic [RW-1:0] rem_r, root_r;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_r  <= rad_d;
        rem_r  <= rem_d;
        root_r <= root_d;
      end
    end
    assign rad_q[k+1]  = rad_r;
    assign rem_q[k+1]  = rem_r;
    assign root_q[k+1] = root_r;
  end

  assign root_o = v3n_pkg::RootW'(root_q[N]);
endmodule

// File: hw/rtl/v3n_div.sv
// Pipelined restoring divider lane, one quotient bit per stage
module v3n_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [v3n_pkg::MagW-1:0]       mag_i,
  input  logic [v3n_pkg::RootW-1:0]      den_i,
  output logic [v3n_pkg::QuoW-1:0]       quo_o
);
  localparam int unsigned N  = v3n_pkg::DivSteps;
  localparam int unsigned W  = v3n_pkg::DivW;
  localparam int unsigned DW = v3n_pkg::RootW;
  localparam int unsigned QW = v3n_pkg::QuoW;

  logic [W-1:0]  num_q [N+1];
  logic [DW:0]   rem_q [N+1];
  logic [DW-1:0] den_q [N+1];
  logic [QW-1:0] quo_q [N+1];

  always_comb begin
    num_q[0] = {mag_i, {v3n_pkg::FracW{1'b0}}};
    rem_q[0] = '0;
    den_q[0] = den_i;
    quo_q[0] = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DW:0]   rem_d;
    logic [QW-1:0] quo_d;
    always_comb begin
      rem_d = {rem_q[k][DW-1:0], num_q[k][W-1]};
      quo_d = {quo_q[k][QW-2:0], 1'b0};
      if (rem_d >= {1'b0, den_q[k]}) begin
        rem_d = rem_d - {1'b0, den_q[k]};
        quo_d = {quo_q[k][QW-2:0], 1'b1};
      end
    end
    logic [W-1:0]  num_r;
    logic [DW:0]   rem_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_r <= {num_q[k][W-2:0], 1'b0};
        rem_r <= rem_d;
        den_r <= den_q[k];
        quo_r <= quo_d;
      end
    end
    assign num_q[k+1] = num_r;
    assign rem_q[k+1] = rem_r;
    assign den_q[k+1] = den_r;
    assign quo_q[k+1] = quo_r;
  end

  assign quo_o = quo_q[N];
endmodule

// File: hw/rtl/vector3_normalize_top.sv
// Top level: three-lane fixed-point vector normalizer
//  channel | direction | signals
//  in      | request   | in_valid_i in_ready_o in_x_i in_y_i in_z_i
//  out     | result    | out_valid_o out_ready_i out_x_o out_y_o out_z_o status_o
// One vector per cycle while the output is not stalled; 3 + 32 + 62 + 1 = 98 register stages.
// The depth is set by the input, square and sum registers, the square-root
// pipeline, the divider lanes and the output register.
// Reset clears the valid bits of all stages.
// A stalled output freezes the whole pipeline; in_ready_o follows out side.
module vector3_normalize_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        status_o
);
  localparam int unsigned D  = v3n_pkg::Depth;
  localparam int unsigned MW = v3n_pkg::MagW;
  localparam int unsigned L  = D - 2;

  logic en;
  logic [D-1:0] vld_q, vld_d;
  assign out_valid_o = vld_q[D-1];
  assign en = !vld_q[D-1] || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    vld_d = {vld_q[D-2:0], in_valid_i};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  logic [31:0] in_c [3];
  assign in_c[0] = in_x_i;
  assign in_c[1] = in_y_i;
  assign in_c[2] = in_z_i;

  v3n_pkg::comp_t c_q [3];
  logic [v3n_pkg::SqW-1:0] sq_q [3];
  logic [v3n_pkg::SqW-1:0] sum_q;
  logic [v3n_pkg::RootW-1:0] root;
  logic [v3n_pkg::QuoW-1:0] quo [3];
  logic [31:0] res_q [3];
  logic [L-1:0] neg_sh_q [3];
  logic [MW-1:0] mag_sh_q [3][v3n_pkg::SqrtSteps+2];
  logic zero_sh_q [v3n_pkg::SqrtSteps + v3n_pkg::DivSteps];
  logic zero_q, stat_q;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [MW-1:0] v;
    assign v = in_c[i][MW-1:0];
    always_ff @(posedge clk_i) begin
      if (en) begin
        c_q[i].neg <= v[MW-1];
        c_q[i].mag <= v[MW-1] ? MW'(~v + 1'b1) : v;
        sq_q[i] <= c_q[i].mag * c_q[i].mag;
        neg_sh_q[i] <= {neg_sh_q[i][L-2:0], c_q[i].neg};
        mag_sh_q[i][0] <= c_q[i].mag;
      end
    end
    for (genvar k = 0; k < v3n_pkg::SqrtSteps + 1; k++) begin : g_dly
      always_ff @(posedge clk_i) begin
        if (en) mag_sh_q[i][k+1] <= mag_sh_q[i][k];
      end
    end
    v3n_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (mag_sh_q[i][v3n_pkg::SqrtSteps+1]),
      .den_i (root),
      .quo_o (quo[i])
    );
    logic [31:0] qx;
    assign qx = 32'(quo[i]);
    always_ff @(posedge clk_i) begin
      if (en) res_q[i] <= zero_q ? 32'd0 : (neg_sh_q[i][L-1] ? (~qx + 32'd1) : qx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
      zero_sh_q[0] <= (sq_q[0] | sq_q[1] | sq_q[2]) == '0;
      zero_q <= zero_sh_q[v3n_pkg::SqrtSteps + v3n_pkg::DivSteps - 1];
      stat_q <= zero_q;
    end
  end
  for (genvar k = 1; k < v3n_pkg::SqrtSteps + v3n_pkg::DivSteps; k++) begin : g_zd
    always_ff @(posedge clk_i) begin
      if (en) zero_sh_q[k] <= zero_sh_q[k-1];
    end
  end

  v3n_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum_q),
    .root_o (root)
  );

  assign out_x_o  = res_q[0];
  assign out_y_o  = res_q[1];
  assign out_z_o  = res_q[2];
  assign status_o = stat_q;

`include "vector3_normalize_top_assert.svh"
  `V3N_ASSERT_IMPL(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o)
  `V3N_ASSERT_NEXT(a_stall_holds_out, out_valid_o && !out_ready_i, out_valid_o && $stable(out_x_o))
  `V3N_ASSERT_IMPL(a_zero_outputs, out_valid_o && status_o, out_x_o == 32'd0 && out_z_o == 32'd0)
endmodule
